// ===== src/nurbs_knot_weight_checker_assert.svh =====
// Assertion macros shared by the NURBS knot and weight checker modules.
// Depends on nothing; every user must have clk and rst_n in scope.
`ifndef NURBS_KNOT_WEIGHT_CHECKER_ASSERT_SVH
`define NURBS_KNOT_WEIGHT_CHECKER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define NKW_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nkw same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define NKW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nkw next-cycle check failed");

`endif

// ===== src/nkw_pkg.sv =====
// Package for the NURBS knot and weight checker: limits, codes and types.
// Used by nkw_dir, nkw_status and the top level; depends on nothing.
package nkw_pkg;

  // Limits of the checked data.
  localparam int MAX_ORDER = 16;
  localparam int MAX_KNOTS = 1024;

  // Field and register widths.
  localparam int TYPE_W  = 2;
  localparam int VALUE_W = 32;
  localparam int ORDER_W = 6;
  localparam int KNOTS_W = 10;
  localparam int TOL_W   = 16;
  localparam int CFG_W   = 16;
  localparam int IDX_W   = 3;
  localparam int STAT_W  = 5;
  localparam int MULT_W  = 10;

  // Request types.
  localparam logic [TYPE_W-1:0] REQ_U_KNOT = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_V_KNOT = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_WEIGHT = 2'd2;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] CFG_ORDER_U   = 3'd0;
  localparam logic [IDX_W-1:0] CFG_ORDER_V   = 3'd1;
  localparam logic [IDX_W-1:0] CFG_KNOTS_U   = 3'd2;
  localparam logic [IDX_W-1:0] CFG_KNOTS_V   = 3'd3;
  localparam logic [IDX_W-1:0] CFG_KNOT_TOL  = 3'd4;
  localparam logic [IDX_W-1:0] CFG_WEIGHT_MIN = 3'd5;

  // Status codes, in falling priority.
  localparam logic [STAT_W-1:0] ST_OK         = 5'd0;
  localparam logic [STAT_W-1:0] ST_U_ORD_LOW  = 5'd1;
  localparam logic [STAT_W-1:0] ST_U_ORD_HIGH = 5'd2;
  localparam logic [STAT_W-1:0] ST_V_ORD_LOW  = 5'd3;
  localparam logic [STAT_W-1:0] ST_V_ORD_HIGH = 5'd4;
  localparam logic [STAT_W-1:0] ST_U_FEW      = 5'd5;
  localparam logic [STAT_W-1:0] ST_V_FEW      = 5'd6;
  localparam logic [STAT_W-1:0] ST_WEIGHT     = 5'd7;
  localparam logic [STAT_W-1:0] ST_NO_KNOTS   = 5'd9;
  localparam logic [STAT_W-1:0] ST_ONLY_U     = 5'd10;
  localparam logic [STAT_W-1:0] ST_ONLY_V     = 5'd11;
  localparam logic [STAT_W-1:0] ST_U_M_START  = 5'd12;
  localparam logic [STAT_W-1:0] ST_U_M_END    = 5'd13;
  localparam logic [STAT_W-1:0] ST_U_M_MID    = 5'd14;
  localparam logic [STAT_W-1:0] ST_V_M_START  = 5'd15;
  localparam logic [STAT_W-1:0] ST_V_M_END    = 5'd16;
  localparam logic [STAT_W-1:0] ST_V_M_MID    = 5'd17;
  localparam logic [STAT_W-1:0] ST_U_DESC     = 5'd18;
  localparam logic [STAT_W-1:0] ST_V_DESC     = 5'd19;

  // Recorded multiplicity error of one direction.
  typedef enum logic [1:0] {
    MERR_NONE  = 2'd0,
    MERR_START = 2'd1,
    MERR_END   = 2'd2,
    MERR_MID   = 2'd3
  } merr_t;

  // Summary of one direction after the current word.
  typedef struct packed {
    logic  seen;
    merr_t mult_error;
    logic  descending;
  } dir_stat_t;

endpackage

// ===== src/nkw_dir.sv =====
// Knot tracker for one direction: multiplicity, descending and presence.
// Depends on nkw_pkg and the assertion macro header.
`include "nurbs_knot_weight_checker_assert.svh"

module nkw_dir (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              take,
  input  logic                              clear,
  input  logic signed [nkw_pkg::VALUE_W-1:0] value,
  input  logic [nkw_pkg::ORDER_W-1:0]       order,
  input  logic [nkw_pkg::KNOTS_W-1:0]       count,
  input  logic [nkw_pkg::TOL_W-1:0]         tol,
  output nkw_pkg::dir_stat_t                stat
);
  import nkw_pkg::*;

  logic [KNOTS_W-1:0]        position_r, position_nxt;
  logic [MULT_W-1:0]         mult_r, mult_nxt;
  logic signed [VALUE_W-1:0] prev_r, prev_nxt;
  merr_t                     merr_r, merr_nxt;
  logic                      desc_r, desc_nxt;
  logic                      seen_r, seen_nxt;

  logic                      in_range;
  logic signed [VALUE_W+1:0] diff;
  logic signed [VALUE_W+1:0] tol_s;
  logic                      near;
  logic                      drop;
  logic [MULT_W-1:0]         mult_inc;
  logic                      zone_start;
  logic                      zone_end;
  logic signed [KNOTS_W+1:0] end_limit;
  merr_t                     merr_upd;
  logic [MULT_W-1:0]         mult_upd;
  logic                      desc_upd;
  logic                      seen_upd;
  logic [KNOTS_W-1:0]        position_upd;
  logic signed [VALUE_W-1:0] prev_upd;

  // Exact difference against the previous knot and the tolerance window.
  assign in_range = (position_r < count) && (32'(position_r) < MAX_KNOTS);
  assign diff  = {{2{prev_r[VALUE_W-1]}}, prev_r} - {{2{value[VALUE_W-1]}}, value};
  assign tol_s = $signed({{(VALUE_W+2-TOL_W){1'b0}}, tol});
  assign near  = (diff < tol_s) && (diff > -tol_s);
  assign drop  = diff > tol_s;

  // Multiplicity count saturates at its top value.
  assign mult_inc = (mult_r == {MULT_W{1'b1}}) ? mult_r : mult_r + MULT_W'(1);

  // Position zones: first order+1 knots, last ones, and the middle.
  assign end_limit  = $signed({2'b00, count}) - $signed({{(KNOTS_W+2-ORDER_W){1'b0}}, order});
  assign zone_start = position_r <= {{(KNOTS_W-ORDER_W){1'b0}}, order};
  assign zone_end   = $signed({2'b00, position_r}) >= end_limit;

  // State after the current word.
  always_comb begin
    merr_upd     = merr_r;
    mult_upd     = mult_r;
    desc_upd     = desc_r;
    seen_upd     = seen_r | take;
    position_upd = position_r;
    prev_upd     = prev_r;
    if (take && in_range) begin
      if (position_r != '0) begin
        if (near) begin
          mult_upd = mult_inc;
          if (zone_start) begin
            if (mult_inc > {{(MULT_W-ORDER_W){1'b0}}, order}) merr_upd = MERR_START;
          end else if (zone_end) begin
            if (mult_inc > {{(MULT_W-ORDER_W){1'b0}}, order}) merr_upd = MERR_END;
          end else begin
            if (mult_inc >= {{(MULT_W-ORDER_W){1'b0}}, order}) merr_upd = MERR_MID;
          end
        end else begin
          mult_upd = MULT_W'(1);
        end
        if (drop) desc_upd = 1'b1;
      end
      prev_upd     = value;
      position_upd = position_r + KNOTS_W'(1);
    end
  end

  assign stat.seen       = seen_upd;
  assign stat.mult_error = merr_upd;
  assign stat.descending = desc_upd;

  // Clear at the end of a set, otherwise keep the updated state.
  always_comb begin
    if (clear) begin
      position_nxt = '0;
      mult_nxt     = MULT_W'(1);
      prev_nxt     = '0;
      merr_nxt     = MERR_NONE;
      desc_nxt     = 1'b0;
      seen_nxt     = 1'b0;
    end else begin
      position_nxt = position_upd;
      mult_nxt     = mult_upd;
      prev_nxt     = prev_upd;
      merr_nxt     = merr_upd;
      desc_nxt     = desc_upd;
      seen_nxt     = seen_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r <= '0;
      mult_r     <= MULT_W'(1);
      prev_r     <= '0;
      merr_r     <= MERR_NONE;
      desc_r     <= 1'b0;
      seen_r     <= 1'b0;
    end else begin
      position_r <= position_nxt;
      mult_r     <= mult_nxt;
      prev_r     <= prev_nxt;
      merr_r     <= merr_nxt;
      desc_r     <= desc_nxt;
      seen_r     <= seen_nxt;
    end
  end

  // A recorded error or a descending flag implies the direction was seen.
  `NKW_ASSERT_SAME(a_merr_seen, merr_r != MERR_NONE, seen_r)
  `NKW_ASSERT_SAME(a_desc_seen, desc_r, seen_r && (position_r != '0))
  // The end of a set leaves the tracker at its reset state.
  `NKW_ASSERT_NEXT(a_clear_state, clear, (position_r == '0) && (mult_r == MULT_W'(1)) && !seen_r)

endmodule

// ===== src/nkw_status.sv =====
// Priority encoder that picks the one status word of a data set.
// Depends on nkw_pkg.
module nkw_status (
  input  logic [nkw_pkg::ORDER_W-1:0] order_u,
  input  logic [nkw_pkg::ORDER_W-1:0] order_v,
  input  logic [nkw_pkg::KNOTS_W-1:0] knots_u,
  input  logic [nkw_pkg::KNOTS_W-1:0] knots_v,
  input  logic                        weight_error,
  input  nkw_pkg::dir_stat_t          u_stat,
  input  nkw_pkg::dir_stat_t          v_stat,
  output logic [nkw_pkg::STAT_W-1:0]  status
);
  import nkw_pkg::*;

  // Checks in falling priority; the first that fails names the status.
  always_comb begin
    if (order_u < ORDER_W'(2)) begin
      status = ST_U_ORD_LOW;
    end else if (32'(order_u) > MAX_ORDER) begin
      status = ST_U_ORD_HIGH;
    end else if (order_v < ORDER_W'(2)) begin
      status = ST_V_ORD_LOW;
    end else if (32'(order_v) > MAX_ORDER) begin
      status = ST_V_ORD_HIGH;
    end else if (knots_u < KNOTS_W'(2)) begin
      status = ST_U_FEW;
    end else if (knots_v < KNOTS_W'(2)) begin
      status = ST_V_FEW;
    end else if (weight_error) begin
      status = ST_WEIGHT;
    end else if (!u_stat.seen && !v_stat.seen) begin
      status = ST_NO_KNOTS;
    end else if (!v_stat.seen) begin
      status = ST_ONLY_U;
    end else if (!u_stat.seen) begin
      status = ST_ONLY_V;
    end else if (u_stat.mult_error != MERR_NONE) begin
      case (u_stat.mult_error)
        MERR_START: status = ST_U_M_START;
        MERR_END:   status = ST_U_M_END;
        default:    status = ST_U_M_MID;
      endcase
    end else if (v_stat.mult_error != MERR_NONE) begin
      case (v_stat.mult_error)
        MERR_START: status = ST_V_M_START;
        MERR_END:   status = ST_V_M_END;
        default:    status = ST_V_M_MID;
      endcase
    end else if (u_stat.descending) begin
      status = ST_U_DESC;
    end else if (v_stat.descending) begin
      status = ST_V_DESC;
    end else begin
      status = ST_OK;
    end
  end

endmodule

// ===== src/nurbs_knot_weight_checker.sv =====
// Top level of the streaming NURBS knot and weight checker.
// Depends on nkw_pkg, nkw_dir, nkw_status and the assertion macro header.
//
//   Channel | Direction | Handshake          | Payload
//   in      | input     | in_valid/in_stall  | req_type, item_value, end_of_set
//   out     | output    | out_valid/out_stall| check_status
//   cfg     | input     | cfg_we             | cfg_index, cfg_wdata
//
// One word per cycle unless stalled: an input register feeds one pass of
// compare and count logic, and a status register holds the result of a
// data set, loaded when the end-of-set word leaves the input register.
// Reset clears all tracking state and loads the register defaults.
// Only an end-of-set word can stall, and only while the status register is
// still full and stalled; other words flow on.
`include "nurbs_knot_weight_checker_assert.svh"

module nurbs_knot_weight_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [nkw_pkg::TYPE_W-1:0]         in_req_type,
  input  logic signed [nkw_pkg::VALUE_W-1:0] in_item_value,
  input  logic                               in_end_of_set,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [nkw_pkg::STAT_W-1:0]         out_check_status,
  input  logic                               cfg_we,
  input  logic [nkw_pkg::IDX_W-1:0]          cfg_index,
  input  logic [nkw_pkg::CFG_W-1:0]          cfg_wdata
);
  import nkw_pkg::*;

  // Configuration registers.
  logic [ORDER_W-1:0] order_u_r, order_v_r;
  logic [KNOTS_W-1:0] knots_u_r, knots_v_r;
  logic [TOL_W-1:0]   tol_r, wmin_r;

  // Input register.
  logic                      s_valid_r, s_valid_nxt;
  logic [TYPE_W-1:0]         s_type_r;
  logic signed [VALUE_W-1:0] s_value_r;
  logic                      s_eos_r;

  // Weight check and status register.
  logic              werr_r, werr_nxt, werr_upd;
  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_status_r;

  logic              in_accept;
  logic              fire;
  logic              out_load;
  logic              clear;
  logic              take_u, take_v, take_w;
  dir_stat_t         u_stat, v_stat;
  logic [STAT_W-1:0] status;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_u_r <= ORDER_W'(4);
      order_v_r <= ORDER_W'(4);
      knots_u_r <= KNOTS_W'(8);
      knots_v_r <= KNOTS_W'(8);
      tol_r     <= TOL_W'(1);
      wmin_r    <= TOL_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ORDER_U:    order_u_r <= cfg_wdata[ORDER_W-1:0];
        CFG_ORDER_V:    order_v_r <= cfg_wdata[ORDER_W-1:0];
        CFG_KNOTS_U:    knots_u_r <= cfg_wdata[KNOTS_W-1:0];
        CFG_KNOTS_V:    knots_v_r <= cfg_wdata[KNOTS_W-1:0];
        CFG_KNOT_TOL:   tol_r     <= cfg_wdata[TOL_W-1:0];
        CFG_WEIGHT_MIN: wmin_r    <= cfg_wdata[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // A word is processed unless it ends a set and the status slot is blocked.
  assign fire      = s_valid_r && (!s_eos_r || !out_valid_r || !out_stall);
  assign in_stall  = s_valid_r && !fire;
  assign in_accept = in_valid && !in_stall;
  assign out_load  = fire && s_eos_r;
  assign clear     = out_load;

  assign s_valid_nxt = in_accept ? 1'b1 : (fire ? 1'b0 : s_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else begin
      s_valid_r <= s_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s_type_r  <= in_req_type;
      s_value_r <= in_item_value;
      s_eos_r   <= in_end_of_set;
    end
  end

  // Route the word to its tracker.
  assign take_u = fire && (s_type_r == REQ_U_KNOT);
  assign take_v = fire && (s_type_r == REQ_V_KNOT);
  assign take_w = fire && (s_type_r == REQ_WEIGHT);

  nkw_dir u_dir (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take_u),
    .clear (clear),
    .value (s_value_r),
    .order (order_u_r),
    .count (knots_u_r),
    .tol   (tol_r),
    .stat  (u_stat)
  );

  nkw_dir v_dir (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take_v),
    .clear (clear),
    .value (s_value_r),
    .order (order_v_r),
    .count (knots_v_r),
    .tol   (tol_r),
    .stat  (v_stat)
  );

  // Weight below the minimum sets a flag that lasts to the end of the set.
  assign werr_upd = werr_r |
                    (take_w && (s_value_r < $signed({{(VALUE_W-TOL_W){1'b0}}, wmin_r})));
  assign werr_nxt = clear ? 1'b0 : werr_upd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      werr_r <= 1'b0;
    end else begin
      werr_r <= werr_nxt;
    end
  end

  nkw_status status_enc (
    .order_u      (order_u_r),
    .order_v      (order_v_r),
    .knots_u      (knots_u_r),
    .knots_v      (knots_v_r),
    .weight_error (werr_upd),
    .u_stat       (u_stat),
    .v_stat       (v_stat),
    .status       (status)
  );

  // Status register: loaded at the end of a set, held while stalled.
  assign out_valid_nxt = out_load ? 1'b1 : (out_stall ? out_valid_r : 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= status;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_check_status = out_status_r;

  // Only a waiting end-of-set word may hold up the input.
  `NKW_ASSERT_SAME(a_stall_cause, in_stall, s_valid_r && s_eos_r && out_valid_r && out_stall)
  // Processing an end-of-set word always makes a status word appear.
  `NKW_ASSERT_NEXT(a_load_valid, out_load, out_valid_r)
  // The status register never loads over a word that is still stalled.
  `NKW_ASSERT_SAME(a_no_overwrite, out_valid_r && out_stall, !out_load)

endmodule

// ===== dv/nkw_set_checker.sv =====
// Checker for the NURBS knot and weight checker: watches the config port and both
// channels, predicts the status word of each data set and compares it on arrival.
// Depends on nkw_pkg for widths, register indexes, status codes and merr_t.
`timescale 1ns / 100ps

module nkw_set_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic [nkw_pkg::TYPE_W-1:0]         in_req_type,
  input  logic signed [nkw_pkg::VALUE_W-1:0] in_item_value,
  input  logic                               in_end_of_set,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic [nkw_pkg::STAT_W-1:0]         out_check_status,
  input  logic                               cfg_we,
  input  logic [nkw_pkg::IDX_W-1:0]          cfg_index,
  input  logic [nkw_pkg::CFG_W-1:0]          cfg_wdata,
  output int                                 fail_count,
  output int                                 pending
);
  import nkw_pkg::*;

  // Running tracking state of one knot direction.
  typedef struct {
    int      position;
    int      multiplicity;
    longint  previous;
    merr_t   merr;
    bit      descending;
    bit      seen;
  } knot_track_t;

  int          ord_u, ord_v, cnt_u, cnt_v;
  longint      knot_tol, weight_min;
  knot_track_t u_trk, v_trk;
  bit          weight_bad;
  logic [STAT_W-1:0] status_due[$];

  function automatic void clear_set();
    u_trk = '{0, 1, 0, MERR_NONE, 1'b0, 1'b0};
    v_trk = '{0, 1, 0, MERR_NONE, 1'b0, 1'b0};
    weight_bad = 1'b0;
  endfunction

  // One knot of a direction: multiplicity count, error region and ordering.
  function automatic void take_knot(inout knot_track_t t, input longint v,
                                    input int ord, input int cnt);
    longint dif;
    longint ord_l;
    longint i1;
    t.seen = 1'b1;
    if (t.position >= cnt || t.position >= MAX_KNOTS) return;
    if (t.position != 0) begin
      dif = t.previous - v;
      if (dif < 0) dif = -dif;
      if (dif < knot_tol) begin
        if (t.multiplicity < 1023) t.multiplicity++;
        i1    = t.position + 1;
        ord_l = ord;
        if (i1 <= ord_l + 1) begin
          if (t.multiplicity > ord_l) t.merr = MERR_START;
        end else if (i1 >= longint'(cnt) - ord_l + 1) begin
          if (t.multiplicity > ord_l) t.merr = MERR_END;
        end else if (t.multiplicity > ord_l - 1) begin
          t.merr = MERR_MID;
        end
      end else begin
        t.multiplicity = 1;
      end
      if (t.previous > v + knot_tol) t.descending = 1'b1;
    end
    t.previous = v;
    t.position++;
  endfunction

  // Status of a finished set, highest priority first.
  function automatic logic [STAT_W-1:0] set_status();
    if (ord_u < 2) return ST_U_ORD_LOW;
    if (ord_u > MAX_ORDER) return ST_U_ORD_HIGH;
    if (ord_v < 2) return ST_V_ORD_LOW;
    if (ord_v > MAX_ORDER) return ST_V_ORD_HIGH;
    if (cnt_u < 2) return ST_U_FEW;
    if (cnt_v < 2) return ST_V_FEW;
    if (weight_bad) return ST_WEIGHT;
    if (!u_trk.seen && !v_trk.seen) return ST_NO_KNOTS;
    if (u_trk.seen && !v_trk.seen) return ST_ONLY_U;
    if (!u_trk.seen && v_trk.seen) return ST_ONLY_V;
    case (u_trk.merr)
      MERR_START: return ST_U_M_START;
      MERR_END:   return ST_U_M_END;
      MERR_MID:   return ST_U_M_MID;
      default:    ;
    endcase
    case (v_trk.merr)
      MERR_START: return ST_V_M_START;
      MERR_END:   return ST_V_M_END;
      MERR_MID:   return ST_V_M_MID;
      default:    ;
    endcase
    if (u_trk.descending) return ST_U_DESC;
    if (v_trk.descending) return ST_V_DESC;
    return ST_OK;
  endfunction

  // Everything happens on the rising edge, with the values that led up to it.
  always @(posedge clk) begin
    longint v;
    logic [STAT_W-1:0] want;
    if (!rst_n) begin
      ord_u      = 4;
      ord_v      = 4;
      cnt_u      = 8;
      cnt_v      = 8;
      knot_tol   = 1;
      weight_min = 1;
      fail_count = 0;
      clear_set();
      status_due.delete();
    end else begin
      // Register writes are to happen only while the block is idle; the checker does not enforce it.
      if (cfg_we) begin
        case (cfg_index)
          CFG_ORDER_U:    ord_u      = int'(cfg_wdata[ORDER_W-1:0]);
          CFG_ORDER_V:    ord_v      = int'(cfg_wdata[ORDER_W-1:0]);
          CFG_KNOTS_U:    cnt_u      = int'(cfg_wdata[KNOTS_W-1:0]);
          CFG_KNOTS_V:    cnt_v      = int'(cfg_wdata[KNOTS_W-1:0]);
          CFG_KNOT_TOL:   knot_tol   = longint'(cfg_wdata[TOL_W-1:0]);
          CFG_WEIGHT_MIN: weight_min = longint'(cfg_wdata[TOL_W-1:0]);
          default:        ;
        endcase
      end

      // Accepted input word: update the prediction.
      if (in_valid && !in_stall) begin
        v = longint'(in_item_value);
        case (in_req_type)
          REQ_U_KNOT: take_knot(u_trk, v, ord_u, cnt_u);
          REQ_V_KNOT: take_knot(v_trk, v, ord_v, cnt_v);
          REQ_WEIGHT: if (v < weight_min) weight_bad = 1'b1;
          default:    ;
        endcase
        if (in_end_of_set) begin
          status_due.push_back(set_status());
          clear_set();
        end
      end

      // Accepted status word: compare with the oldest prediction.
      if (out_valid && !out_stall) begin
        if (status_due.size() == 0) begin
          $error("check_status: unexpected word, expected none, got %0d", out_check_status);
          fail_count++;
        end else begin
          want = status_due.pop_front();
          if (out_check_status !== want) begin
            $error("check_status mismatch: expected %0d, got %0d", want, out_check_status);
            fail_count++;
          end
        end
      end
    end
    pending = status_due.size();
  end

endmodule

// ===== dv/tb.sv =====
// Testbench top for the NURBS knot and weight checker: clock, reset, stimulus
// phases over several register settings, and the verdict.
// Depends on nkw_pkg, the block itself and nkw_set_checker.
`timescale 1ns / 100ps

module tb;
  import nkw_pkg::*;

  // Request type that the block does not use.
  localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [TYPE_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
    logic               last;
  } word_t;

  logic                       clk;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [TYPE_W-1:0]          in_req_type = '0;
  logic signed [VALUE_W-1:0]  in_item_value = '0;
  logic                       in_end_of_set = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [STAT_W-1:0]          out_check_status;
  logic                       cfg_we = 1'b0;
  logic [IDX_W-1:0]           cfg_index = '0;
  logic [CFG_W-1:0]           cfg_wdata = '0;

  int idle_pct = 0;
  int stall_pct = 0;
  int fail_count;
  int pending;

  nurbs_knot_weight_checker dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_item_value    (in_item_value),
    .in_end_of_set    (in_end_of_set),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_check_status (out_check_status),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  nkw_set_checker chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_item_value    (in_item_value),
    .in_end_of_set    (in_end_of_set),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_check_status (out_check_status),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  // 10 ns clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Receiver stalls at random, at the rate of the current phase.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Present one word, after random idle cycles, and hold it until taken.
  task automatic send_word(input word_t w);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= w.kind;
    in_item_value <= w.value;
    in_end_of_set <= w.last;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Stop sending until every predicted status word has come, then let the
  // pipeline settle before anything else happens.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write one register; the caller lowers the write enable afterwards.
  task automatic write_reg(input logic [IDX_W-1:0] idx, input int data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data[CFG_W-1:0];
    @(negedge clk);
  endtask

  // Knot vector of one direction: clamped ends, mostly ascending middle,
  // with repeats, near-equal steps, drops and wild values mixed in.
  task automatic make_knots(input logic [TYPE_W-1:0] kind, input int ord, input int n,
                            input int tol, output word_t q[$]);
    longint val;
    int     r;
    bit     clamped;
    q.delete();
    if ($urandom_range(4) == 0)
      val = longint'($signed($urandom));
    else
      val = longint'($urandom_range(1 << 22)) - (1 << 21);
    for (int i = 0; i < n; i++) begin
      if (i > 0) begin
        clamped = (i < ord) || (i >= n - ord);
        r = $urandom_range(99);
        if (clamped && r < 90)
          val = val;
        else if (r < 20)
          val = val;
        else if (r < 30)
          val = val + ((tol > 1) ? $urandom_range(tol - 1) : 0);
        else if (r < 35)
          val = val - $urandom_range(1 << 20, 1);
        else if (r < 38)
          val = longint'($signed($urandom));
        else
          val = val + tol + $urandom_range(1 << 20, 1);
      end
      q.push_back('{kind, val[VALUE_W-1:0], 1'b0});
    end
  endtask

  // One phase: settle, load all registers, then random data sets.
  task automatic run_phase(input int ou, input int ov, input int ku, input int kv,
                           input int tol, input int wmin, input int idle,
                           input int stall, input int budget);
    word_t uq[$], vq[$], wq[$], set_q[$];
    word_t w;
    int    sent;
    int    nu, nv, nw, r, total;
    drain();
    write_reg(CFG_ORDER_U, ou);
    write_reg(CFG_ORDER_V, ov);
    write_reg(CFG_KNOTS_U, ku);
    write_reg(CFG_KNOTS_V, kv);
    write_reg(CFG_KNOT_TOL, tol);
    write_reg(CFG_WEIGHT_MIN, wmin);
    cfg_we    <= 1'b0;
    idle_pct  = idle;
    stall_pct = stall;
    sent = 0;
    while (sent < budget) begin
      // Now and then hold off until the block has delivered everything.
      if ($urandom_range(7) == 0) drain();

      // Occasional loose noise words of any kind.
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(3, 1)) begin
          w = '{$urandom_range(3), $urandom, ($urandom_range(7) == 0)};
          send_word(w);
          sent++;
        end
      end

      // Knot counts: as configured up to 48, else random; sometimes short, long or absent.
      nu = (ku > 48) ? $urandom_range(48, 2) : ku;
      nv = (kv > 48) ? $urandom_range(48, 2) : kv;
      r = $urandom_range(99);
      if (r < 8) nu = $urandom_range(nu);
      else if (r < 14) nu = nu + $urandom_range(3, 1);
      else if (r < 17) nu = 0;
      r = $urandom_range(99);
      if (r < 8) nv = $urandom_range(nv);
      else if (r < 14) nv = nv + $urandom_range(3, 1);
      else if (r < 17) nv = 0;
      make_knots(REQ_U_KNOT, ou, nu, tol, uq);
      make_knots(REQ_V_KNOT, ov, nv, tol, vq);

      // Weights: mostly at or above the minimum.
      nw = $urandom_range(8);
      wq.delete();
      for (int i = 0; i < nw; i++) begin
        r = $urandom_range(99);
        if (r < 5)
          w = '{REQ_WEIGHT, VALUE_W'(wmin - $urandom_range(100, 1)), 1'b0};
        else if (r < 15)
          w = '{REQ_WEIGHT, $urandom, 1'b0};
        else
          w = '{REQ_WEIGHT, VALUE_W'(wmin + $urandom_range(1 << 20)), 1'b0};
        wq.push_back(w);
      end

      // Interleave the three streams, keeping each in order.
      set_q.delete();
      total = uq.size() + vq.size() + wq.size();
      while (total > 0) begin
        if ($urandom_range(99) < 3) set_q.push_back('{REQ_UNUSED, $urandom, 1'b0});
        r = $urandom_range(total - 1);
        if (r < uq.size()) set_q.push_back(uq.pop_front());
        else if (r < uq.size() + vq.size()) set_q.push_back(vq.pop_front());
        else set_q.push_back(wq.pop_front());
        total--;
      end
      if (set_q.size() == 0) set_q.push_back('{REQ_UNUSED, $urandom, 1'b0});
      set_q[set_q.size() - 1].last = 1'b1;

      foreach (set_q[i]) send_word(set_q[i]);
      sent += set_q.size();
    end
  endtask

  // Stimulus.
  initial begin
    int waited;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed sets under the reset register values.
    send_word('{REQ_UNUSED, 32'h0000_0000, 1'b1});          // no knots at all
    send_word('{REQ_U_KNOT, 32'h8000_0000, 1'b1});          // only U knots
    send_word('{REQ_V_KNOT, 32'h7FFF_FFFF, 1'b1});          // only V knots
    send_word('{REQ_WEIGHT, 32'h0000_0000, 1'b1});          // weight below minimum
    send_word('{REQ_U_KNOT, 32'h0005_0000, 1'b0});          // U descending
    send_word('{REQ_U_KNOT, 32'h0003_0000, 1'b0});
    send_word('{REQ_V_KNOT, 32'h0000_0000, 1'b0});
    send_word('{REQ_V_KNOT, 32'h0001_0000, 1'b0});
    send_word('{REQ_WEIGHT, 32'h7FFF_FFFF, 1'b1});
    send_word('{REQ_U_KNOT, 32'h0000_0000, 1'b0});          // V descending
    send_word('{REQ_U_KNOT, 32'h0001_0000, 1'b0});
    send_word('{REQ_V_KNOT, 32'h0002_0000, 1'b0});
    send_word('{REQ_V_KNOT, 32'h0001_0000, 1'b1});
    send_word('{REQ_U_KNOT, 32'hFFFF_FFFF, 1'b0});          // all ones, clean set
    send_word('{REQ_V_KNOT, 32'hFFFF_FFFF, 1'b0});
    send_word('{REQ_WEIGHT, 32'h0000_0001, 1'b1});
    send_word('{REQ_U_KNOT, 32'h0000_0000, 1'b0});          // repeated U knot at start
    send_word('{REQ_U_KNOT, 32'h0000_0000, 1'b0});
    send_word('{REQ_U_KNOT, 32'h0000_0000, 1'b0});
    send_word('{REQ_U_KNOT, 32'h0000_0000, 1'b0});
    send_word('{REQ_U_KNOT, 32'h0000_0000, 1'b0});
    send_word('{REQ_V_KNOT, 32'h0000_0000, 1'b1});

    // Random phases over several settings, extremes among them.
    run_phase(4, 4, 8, 8, 1, 1, 0, 0, 150);
    run_phase(2, 3, 6, 5, 0, 0, 62, 0, 120);
    run_phase(3, 2, 12, 10, 65535, 65535, 0, 62, 120);
    run_phase(16, 16, 40, 20, 256, 4096, 33, 33, 140);
    run_phase(0, 1, 5, 5, 1, 1, 62, 0, 30);
    run_phase(17, 63, 5, 5, 1, 1, 0, 62, 30);
    run_phase(4, 0, 5, 5, 1, 1, 33, 33, 30);
    run_phase(4, 63, 5, 5, 1, 1, 0, 0, 30);
    run_phase(4, 4, 0, 6, 1, 1, 62, 0, 30);
    run_phase(4, 4, 6, 1, 1, 1, 0, 62, 30);
    run_phase(5, 4, 1023, 3, 16, 100, 33, 33, 60);
    run_phase(2, 2, 4, 4, 16, 100, 33, 33, 120);

    // Wait for the last status words, bounded, then give the verdict.
    in_valid <= 1'b0;
    waited = 0;
    while (pending != 0 && waited < 20000) begin
      @(negedge clk);
      waited++;
    end
    repeat (8) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("** nurbs_knot_weight_checker: PASSED **");
    end else begin
      if (pending != 0) $error("check_status: %0d expected words never arrived", pending);
      $display("** nurbs_knot_weight_checker: FAILED **");
    end
    $finish;
  end

  // Hard limit on the whole run.
  initial begin
    #2_000_000;
    $display("** nurbs_knot_weight_checker: FAILED **");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/nkw_pkg.sv
src/nkw_dir.sv
src/nkw_status.sv
src/nurbs_knot_weight_checker.sv
dv/nkw_set_checker.sv
dv/tb.sv
